@@ rtl/core/lhw_pkg.sv @@
// lhw_pkg: shared types and constants of the latency histogram window block
// beat structs for the sample and report channels, register codes, reset values
// no dependencies
package lhw_pkg;

	localparam int CYCLES_W    = 32;
	localparam int COUNT_W     = 16;
	localparam int TOTAL_W     = 48;
	localparam int SAMPLES_W   = 16;
	localparam int CEILING_W   = 21;
	localparam int SEARCH_W    = CYCLES_W + 1;
	localparam int MAX_WORDS   = 16;
	localparam int STAT_WORDS  = 4;
	localparam int WORD_IDX_W  = 4;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [SAMPLES_W-1:0] REPORT_SAMPLES_RST = 16'd1024;
	localparam logic [CEILING_W-1:0] FIRST_CEILING_RST  = 21'd64;

	// register index, taken from paddr[2]
	localparam logic REG_REPORT_SAMPLES = 1'b0;
	localparam logic REG_FIRST_CEILING  = 1'b1;

	// statistic word codes
	localparam logic [1:0] WORD_SAMPLES  = 2'd0;
	localparam logic [1:0] WORD_FAILURES = 2'd1;
	localparam logic [1:0] WORD_TOTAL    = 2'd2;
	localparam logic [1:0] WORD_MAXIMUM  = 2'd3;

	typedef struct packed {
		logic                source;
		logic                is_encrypt;
		logic [CYCLES_W-1:0] cycles;
		logic                failed;
	} sample_t;

	typedef struct packed {
		logic                  report_source;
		logic                  report_encrypt;
		logic [WORD_IDX_W-1:0] word_index;
		logic [TOTAL_W-1:0]    word_value;
		logic                  last_word;
	} report_t;

endpackage

@@ rtl/core/lhw_ram.sv @@
// lhw_ram: generic single write port, single read port ram with registered read
// read data holds while re is low
// no dependencies
module lhw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/lhw_bin_search.sv @@
// lhw_bin_search: iterative bucket search, one compare and one doubling per cycle
// walks the ceiling up from the first bucket bound until the count fits or the last bucket is reached
// depends on lhw_pkg
module lhw_bin_search #(
	parameter int BINS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lhw_pkg::CYCLES_W-1:0] cycles,
	input  logic [lhw_pkg::CEILING_W-1:0] ceiling,
	output logic                         done,
	output logic [$clog2(BINS)-1:0]      bin
);

	import lhw_pkg::*;

	localparam int BIN_W = $clog2(BINS);

	logic                busy_q;
	logic [SEARCH_W-1:0] ceil_q;
	logic [CYCLES_W-1:0] cyc_q;
	logic [BIN_W-1:0]    bin_q;
	logic                step;

	assign step = (bin_q != BIN_W'(BINS - 1)) && ({1'b0, cyc_q} > ceil_q);
	assign done = busy_q && !step;
	assign bin  = bin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ceil_q <= SEARCH_W'(ceiling);
			cyc_q  <= cycles;
			bin_q  <= '0;
		end else if (busy_q && step) begin
			bin_q <= bin_q + BIN_W'(1);
			if (!ceil_q[SEARCH_W-1]) begin
				ceil_q <= {ceil_q[SEARCH_W-2:0], 1'b0};
			end
		end
	end

endmodule

@@ rtl/core/latency_histogram_window.sv @@
// latency_histogram_window: top level, sequencer, window statistics and report drain
// instantiates lhw_bin_search and lhw_ram (bucket counters)
// depends on lhw_pkg
//
// usage:
//  sample channel (sample_valid, sample_stall, sample) carries one measured
//  operation per beat. window = source*2 + (is_encrypt ? 0 : 1); a source at
//  or above SOURCES is taken and dropped. sample_stall stays high while a
//  beat is in work: the bucket search walks up one bucket at a time, and the
//  input stays stalled through the search and the bucket update, so the next
//  sample is taken only after both. the search unit sets the pace.
//  when the window count reaches report_samples, the window drains as
//  min(4+BINS,16) report beats (samples, failures, total, maximum, buckets),
//  and is cleared. report beats sit in an output register; report_stall
//  holds that beat and pauses the drain, samples keep being blocked until
//  the drain ends. after reset the bucket ram is zeroed, one entry a cycle,
//  through all 2*SOURCES*BINS entries with sample_stall high; apb writes are
//  taken always.
//  registers: 0x0 report_samples (reset 1024), 0x4 first_bin_ceiling (reset 64)
module latency_histogram_window #(
	parameter int SOURCES = 2,
	parameter int BINS    = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  lhw_pkg::sample_t            sample,
	output logic                        report_valid,
	input  logic                        report_stall,
	output lhw_pkg::report_t            report,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lhw_pkg::PADDR_W-1:0] paddr,
	input  logic [lhw_pkg::PDATA_W-1:0] pwdata,
	output logic [lhw_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	import lhw_pkg::*;

	localparam int WINDOWS  = 2 * SOURCES;
	localparam int WIN_W    = $clog2(WINDOWS);
	localparam int DEPTH    = WINDOWS * BINS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int BIN_W    = $clog2(BINS);
	localparam int REP_BINS = (BINS < MAX_WORDS - STAT_WORDS) ? BINS : MAX_WORDS - STAT_WORDS;

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_SEARCH   = 3'd2;
	localparam logic [2:0] ST_BUMP     = 3'd3;
	localparam logic [2:0] ST_RPT_STAT = 3'd4;
	localparam logic [2:0] ST_RPT_RD   = 3'd5;
	localparam logic [2:0] ST_RPT_EMIT = 3'd6;

	logic [2:0]           state_q;
	logic [SAMPLES_W-1:0] report_samples_q;
	logic [CEILING_W-1:0] first_ceiling_q;

	logic [COUNT_W-1:0]  samples_q  [WINDOWS];
	logic [COUNT_W-1:0]  failures_q [WINDOWS];
	logic [TOTAL_W-1:0]  total_q    [WINDOWS];
	logic [CYCLES_W-1:0] maximum_q  [WINDOWS];

	logic [WIN_W-1:0]    win_q;
	logic                src_q;
	logic                enc_q;
	logic                failed_q;
	logic [CYCLES_W-1:0] cycles_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [BIN_W-1:0]    rb_q;
	logic [1:0]          k_q;

	logic                out_valid_q;
	report_t             out_q;

	logic                accept;
	logic                in_range;
	logic [WIN_W:0]      win_full;
	logic                srch_done;
	logic [BIN_W-1:0]    srch_bin;
	logic [ADDR_W-1:0]   base_addr;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [COUNT_W-1:0]  ram_rdata;
	logic [COUNT_W-1:0]  samples_next;
	logic                out_free;
	logic                rpt_emit;
	logic                ld;
	report_t             ld_data;
	logic                cfg_we;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_samples_q <= REPORT_SAMPLES_RST;
			first_ceiling_q  <= FIRST_CEILING_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_REPORT_SAMPLES: report_samples_q <= pwdata[SAMPLES_W-1:0];
				REG_FIRST_CEILING:  first_ceiling_q  <= pwdata[CEILING_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_REPORT_SAMPLES: prdata = PDATA_W'(report_samples_q);
			REG_FIRST_CEILING:  prdata = PDATA_W'(first_ceiling_q);
			default:            prdata = '0;
		endcase
	end

	// input side
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign in_range     = 32'(sample.source) < SOURCES;
	assign win_full     = {WIN_W'(sample.source), ~sample.is_encrypt};

	lhw_bin_search #(
		.BINS(BINS)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && in_range),
		.cycles (sample.cycles),
		.ceiling(first_ceiling_q),
		.done   (srch_done),
		.bin    (srch_bin)
	);

	assign base_addr    = ADDR_W'(win_q) * ADDR_W'(BINS);
	assign samples_next = samples_q[win_q] + COUNT_W'(1);

	// output register
	assign out_free = !out_valid_q || !report_stall;
	assign rpt_emit = 32'(rb_q) < REP_BINS;

	always_comb begin
		ld                     = 1'b0;
		ld_data.report_source  = src_q;
		ld_data.report_encrypt = enc_q;
		ld_data.word_index     = WORD_IDX_W'(k_q);
		ld_data.word_value     = '0;
		ld_data.last_word      = 1'b0;
		if (state_q == ST_RPT_STAT) begin
			ld = out_free;
			case (k_q)
				WORD_SAMPLES:  ld_data.word_value = TOTAL_W'(samples_q[win_q]);
				WORD_FAILURES: ld_data.word_value = TOTAL_W'(failures_q[win_q]);
				WORD_TOTAL:    ld_data.word_value = total_q[win_q];
				WORD_MAXIMUM:  ld_data.word_value = TOTAL_W'(maximum_q[win_q]);
				default:       ld_data.word_value = '0;
			endcase
		end else if (state_q == ST_RPT_EMIT) begin
			ld                 = out_free && rpt_emit;
			ld_data.word_index = WORD_IDX_W'(rb_q) + WORD_IDX_W'(STAT_WORDS);
			ld_data.word_value = TOTAL_W'(ram_rdata);
			ld_data.last_word  = (rb_q == BIN_W'(REP_BINS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!report_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_q <= ld_data;
		end
	end

	assign report_valid = out_valid_q;
	assign report       = out_q;

	// bucket ram
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = base_addr + ADDR_W'(rb_q);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_SEARCH: begin
				ram_re    = srch_done;
				ram_raddr = base_addr + ADDR_W'(srch_bin);
			end
			ST_BUMP: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata + COUNT_W'(1);
			end
			ST_RPT_RD: begin
				ram_re = 1'b1;
			end
			ST_RPT_EMIT: begin
				ram_we = !rpt_emit || out_free;
			end
			default: ;
		endcase
	end

	lhw_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_buckets (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			rb_q    <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_range) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (srch_done) begin
						state_q <= ST_BUMP;
					end
				end
				ST_BUMP: begin
					k_q  <= '0;
					rb_q <= '0;
					if (32'(samples_next) >= 32'(report_samples_q)) begin
						state_q <= ST_RPT_STAT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RPT_STAT: begin
					if (out_free) begin
						k_q <= k_q + 2'd1;
						if (k_q == WORD_MAXIMUM) begin
							state_q <= ST_RPT_RD;
						end
					end
				end
				ST_RPT_RD: begin
					state_q <= ST_RPT_EMIT;
				end
				ST_RPT_EMIT: begin
					if (!rpt_emit || out_free) begin
						rb_q <= rb_q + BIN_W'(1);
						if (rb_q == BIN_W'(BINS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RPT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample capture and read address
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q    <= win_full[WIN_W-1:0];
			src_q    <= sample.source;
			enc_q    <= sample.is_encrypt;
			failed_q <= sample.failed;
			cycles_q <= sample.cycles;
		end
		if (ram_re) begin
			addr_q <= ram_raddr;
		end
	end

	// window statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOWS; i++) begin
				samples_q[i]  <= '0;
				failures_q[i] <= '0;
				total_q[i]    <= '0;
				maximum_q[i]  <= '0;
			end
		end else if (state_q == ST_BUMP) begin
			samples_q[win_q] <= samples_next;
			if (failed_q) begin
				failures_q[win_q] <= failures_q[win_q] + COUNT_W'(1);
			end
			total_q[win_q] <= total_q[win_q] + TOTAL_W'(cycles_q);
			if (cycles_q > maximum_q[win_q]) begin
				maximum_q[win_q] <= cycles_q;
			end
		end else if (state_q == ST_RPT_EMIT && ram_we && rb_q == BIN_W'(BINS - 1)) begin
			samples_q[win_q]  <= '0;
			failures_q[win_q] <= '0;
			total_q[win_q]    <= '0;
			maximum_q[win_q]  <= '0;
		end
	end

	// checks
	a_search_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> state_q == ST_SEARCH)
		else $error("bucket search finished outside the search state");

	a_bump_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUMP |=> (state_q == ST_IDLE || state_q == ST_RPT_STAT))
		else $error("bucket update not followed by idle or report");

	a_last_from_bins: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_data.last_word) |-> state_q == ST_RPT_EMIT)
		else $error("last report beat not taken from a bucket");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> out_free)
		else $error("report beat loaded over a held beat");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for latency_histogram_window, directed then random samples
// window_scoreboard predicts every report beat; depends on lhw_pkg and the block rtl

class window_scoreboard #(int SOURCES = 2, int BINS = 12);
	localparam int WINDOWS = SOURCES * 2;
	localparam int REPORT_WORDS = (lhw_pkg::STAT_WORDS + BINS < lhw_pkg::MAX_WORDS) ?
		lhw_pkg::STAT_WORDS + BINS : lhw_pkg::MAX_WORDS;

	logic [15:0] report_samples;
	logic [20:0] first_ceiling;
	logic [15:0] samples [WINDOWS];
	logic [15:0] failures [WINDOWS];
	logic [47:0] total [WINDOWS];
	logic [31:0] maximum [WINDOWS];
	logic [15:0] buckets [WINDOWS][BINS];
	lhw_pkg::report_t reports_due [$];
	int errors;

	function new();
		report_samples = lhw_pkg::REPORT_SAMPLES_RST;
		first_ceiling = lhw_pkg::FIRST_CEILING_RST;
		errors = 0;
		for (int w = 0; w < WINDOWS; w++) begin
			clear_window(w);
		end
	endfunction

	function void clear_window(int w);
		samples[w] = '0;
		failures[w] = '0;
		total[w] = '0;
		maximum[w] = '0;
		for (int b = 0; b < BINS; b++) begin
			buckets[w][b] = '0;
		end
	endfunction

	function void set_reg(logic idx, logic [31:0] value);
		if (idx == lhw_pkg::REG_REPORT_SAMPLES) begin
			report_samples = value[15:0];
		end else begin
			first_ceiling = value[20:0];
		end
	endfunction

	function int unsigned bucket_of(logic [31:0] cycles);
		logic [63:0] ceiling;
		int unsigned b;
		ceiling = 64'(first_ceiling);
		b = 0;
		while (b < BINS - 1 && 64'(cycles) > ceiling) begin
			if (ceiling < 64'h100_0000_0000) begin
				ceiling = ceiling << 1;
			end
			b++;
		end
		return b;
	endfunction

	function void note_sample(lhw_pkg::sample_t s);
		int unsigned w;
		int unsigned b;
		lhw_pkg::report_t r;
		logic [47:0] v;
		if (int'(s.source) >= SOURCES) begin
			return;
		end
		w = 2 * int'(s.source) + (s.is_encrypt ? 0 : 1);
		samples[w] = samples[w] + 16'd1;
		if (s.failed) begin
			failures[w] = failures[w] + 16'd1;
		end
		total[w] = total[w] + 48'(s.cycles);
		if (s.cycles > maximum[w]) begin
			maximum[w] = s.cycles;
		end
		b = bucket_of(s.cycles);
		buckets[w][b] = buckets[w][b] + 16'd1;
		if (samples[w] < report_samples) begin
			return;
		end
		for (int k = 0; k < REPORT_WORDS; k++) begin
			case (k)
				0: v = 48'(samples[w]);
				1: v = 48'(failures[w]);
				2: v = total[w];
				3: v = 48'(maximum[w]);
				default: v = 48'(buckets[w][k - lhw_pkg::STAT_WORDS]);
			endcase
			r.report_source = s.source;
			r.report_encrypt = s.is_encrypt;
			r.word_index = 4'(k);
			r.word_value = v;
			r.last_word = (k == REPORT_WORDS - 1);
			reports_due.push_back(r);
		end
		clear_window(w);
	endfunction

	function void check_report(lhw_pkg::report_t got);
		lhw_pkg::report_t want;
		if (reports_due.size() == 0) begin
			$error("report beat with none expected: word_index %0d word_value %0h",
				got.word_index, got.word_value);
			errors++;
			return;
		end
		want = reports_due.pop_front();
		if (got.report_source !== want.report_source) begin
			$error("report_source: expected %0d, actual %0d", want.report_source,
				got.report_source);
			errors++;
		end
		if (got.report_encrypt !== want.report_encrypt) begin
			$error("report_encrypt: expected %0d, actual %0d", want.report_encrypt,
				got.report_encrypt);
			errors++;
		end
		if (got.word_index !== want.word_index) begin
			$error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
			errors++;
		end
		if (got.word_value !== want.word_value) begin
			$error("word_value: expected %0h, actual %0h", want.word_value, got.word_value);
			errors++;
		end
		if (got.last_word !== want.last_word) begin
			$error("last_word: expected %0d, actual %0d", want.last_word, got.last_word);
			errors++;
		end
	endfunction
endclass

module tb;
	import lhw_pkg::*;

	localparam int SOURCES = 2;
	localparam int BINS = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic report_valid;
	logic report_stall = 1'b0;
	report_t report;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	int cycle_count = 0;
	int send_quiet = 0;
	int take_quiet = 0;
	window_scoreboard #(SOURCES, BINS) sb;

	latency_histogram_window #(
		.SOURCES(SOURCES),
		.BINS(BINS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.report_valid(report_valid),
		.report_stall(report_stall),
		.report(report),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("latency_histogram_window regression: fail");
		$finish;
	end

	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(4, 16);
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic send_sample(input logic src, input logic enc, input logic [31:0] cyc,
		input logic fail);
		int gap;
		gap = draw_gap(send_quiet);
		repeat (gap) begin
			@(negedge clk);
			sample_valid = 1'b0;
		end
		@(negedge clk);
		sample_valid = 1'b1;
		sample.source = src;
		sample.is_encrypt = enc;
		sample.cycles = cyc;
		sample.failed = fail;
		do @(posedge clk); while (sample_stall !== 1'b0);
		sb.note_sample(sample);
	endtask

	// drop valid, drain every report, then let any silent sample finish
	task automatic settle();
		@(negedge clk);
		sample_valid = 1'b0;
		while (sb.reports_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [31:0] want;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_reg(idx, value);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		want = (idx == REG_REPORT_SAMPLES) ? 32'(sb.report_samples) : 32'(sb.first_ceiling);
		if (prdata !== want) begin
			$error("prdata: expected %0h, actual %0h", want, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_gap(take_quiet);
			repeat (hold) begin
				@(negedge clk);
				report_stall = 1'b1;
			end
			@(negedge clk);
			report_stall = 1'b0;
			do @(posedge clk); while (report_valid !== 1'b1);
			sb.check_report(report);
		end
	end

	initial begin
		int report_limit;
		logic [20:0] ceiling;
		logic [31:0] cyc;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset thresholds: windows fill without reporting
		send_sample(0, 1, 32'd0, 0);
		send_sample(0, 0, 32'd64, 1);
		send_sample(1, 1, 32'd65, 0);
		send_sample(1, 0, 32'hFFFF_FFFF, 1);
		settle();

		// threshold lowered to the held counts
		write_reg(REG_REPORT_SAMPLES, 32'd1);
		send_sample(0, 1, 32'd128, 1);
		send_sample(0, 0, 32'd129, 0);
		send_sample(1, 1, 32'd1, 1);
		send_sample(1, 0, 32'd65536, 0);
		send_sample(0, 1, 32'd65537, 1);
		settle();

		// zero ceiling
		write_reg(REG_FIRST_CEILING, 32'd0);
		send_sample(1, 0, 32'd0, 0);
		send_sample(0, 1, 32'd1, 1);
		send_sample(1, 1, 32'hFFFF_FFFF, 0);
		settle();

		write_reg(REG_FIRST_CEILING, 32'h001F_FFFF);
		send_sample(0, 0, 32'h001F_FFFF, 1);
		send_sample(1, 1, 32'h0020_0000, 0);
		send_sample(0, 1, 32'hFFFF_FFFF, 1);
		settle();

		// upper bits beyond the register are dropped
		write_reg(REG_FIRST_CEILING, 32'hFFF0_0000);
		send_sample(1, 0, 32'h0010_0000, 0);
		send_sample(0, 0, 32'h0010_0001, 1);
		settle();

		// zero threshold reports on every sample
		write_reg(REG_REPORT_SAMPLES, 32'd0);
		send_sample(1, 1, 32'd7, 1);
		send_sample(0, 0, 32'h8000_0000, 0);
		settle();

		write_reg(REG_REPORT_SAMPLES, 32'h0000_FFFF);
		write_reg(REG_FIRST_CEILING, 32'd64);
		send_sample(0, 1, 32'd100, 0);
		send_sample(1, 0, 32'd3000, 1);
		settle();
		write_reg(REG_REPORT_SAMPLES, 32'd2);
		send_sample(0, 1, 32'd50, 1);
		send_sample(1, 0, 32'd5000, 0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			report_limit = (p == RANDOM_PHASES - 1) ? $urandom_range(6, 12) : $urandom_range(1, 5);
			case ($urandom_range(0, 3))
				0: ceiling = 21'($urandom_range(1, 256));
				1: ceiling = 21'($urandom);
				2: ceiling = 21'd1;
				default: ceiling = 21'($urandom_range(1, 4096));
			endcase
			write_reg(REG_REPORT_SAMPLES, 32'(report_limit));
			write_reg(REG_FIRST_CEILING, 32'(ceiling));
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				case ($urandom_range(0, 3))
					0: cyc = $urandom;
					1: cyc = ({11'd0, ceiling} << $urandom_range(0, BINS - 1))
						+ $urandom_range(0, 2) - 1;
					2: cyc = $urandom_range(0, 255);
					default: cyc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
				endcase
				send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cyc,
					1'($urandom_range(0, 1)));
			end
		end
		settle();

		if (sb.errors == 0) begin
			$display("latency_histogram_window regression: pass");
		end else begin
			$display("latency_histogram_window regression: fail");
		end
		$finish;
	end
endmodule
